// File: rtl/utc_pkg.sv
// Shared types and constants for the timestamp to calendar converter.
// No dependencies; used by utc_sub_unit and unix_time_to_calendar.
package utc_pkg;

   localparam int UNIT_W = 18;              // shared subtractor width
   localparam int DAYS_W = 16;              // whole days since epoch fit 16 bits
   localparam int SOD_W  = 17;              // seconds of day, below 86400

   localparam logic [UNIT_W-1:0] SECS_IN_DAY  = 18'd86400;
   localparam logic [UNIT_W-1:0] SECS_IN_HOUR = 18'd3600;
   localparam logic [UNIT_W-1:0] SECS_IN_MIN  = 18'd60;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   localparam logic [3:0] DIV_LAST_STEP = 4'd15;   // 16 quotient bits
   localparam logic [3:0] HOUR_TOP_BIT  = 4'd4;    // hour quotient bits 4..0
   localparam logic [3:0] MIN_TOP_BIT   = 4'd5;    // minute quotient bits 5..0

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_DIV   = 7'b0000010,
      ST_YEAR  = 7'b0000100,
      ST_MONTH = 7'b0001000,
      ST_HOUR  = 7'b0010000,
      ST_MIN   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic              ge;     // minuend >= subtrahend
      logic [UNIT_W-1:0] value;  // difference if ge, else minuend unchanged
   } sub_result_type;

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m)
         MONTH_FEB:               len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// File: rtl/unix_time_to_calendar.sv
// Top level: seconds since 1970-01-01 UTC to Gregorian date and time of day.
// Depends on utc_pkg and utc_sub_unit.
//
//  channel | direction | tdata fields (low bit up)
//  req_    | in        | timestamp[31:0]
//  rsp_    | out       | year[11:0] month[15:12] day_of_month[20:16] hour[25:21]
//          |           | minute[31:26] second[37:32], zero fill [39:38]
//
// One transaction runs through acceptance, bit-serial day division, one year step
// per elapsed year plus a final one, the month steps, the hour and minute
// quotient bits and the result hold. The division, year, month, hour and minute
// steps share one 18-bit subtractor.
// Reset is synchronous, active high, and clears only the sequencer.
// req_tready is high only while idle; the result holds until rsp_tready.
module unix_time_to_calendar
   import utc_pkg::*;
#(
   parameter int BASE_YEAR = 1970
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // timestamp[31:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // year, month, day_of_month, hour, minute, second
);

   localparam logic [11:0] YEAR_INIT = 12'(BASE_YEAR);
   localparam logic [1:0]  Y4_INIT   = 2'(BASE_YEAR % 4);
   localparam logic [6:0]  Y100_INIT = 7'(BASE_YEAR % 100);
   localparam logic [8:0]  Y400_INIT = 9'(BASE_YEAR % 400);

   state_type          state_ff, state_in;
   logic [SOD_W-1:0]   rem_ff, rem_in;       // division remainder, then seconds of day
   logic [DAYS_W-1:0]  days_ff, days_in;     // dividend low half, then days left
   logic [3:0]         step_ff, step_in;
   logic [11:0]        year_ff, year_in;
   logic [1:0]         y4_ff, y4_in;
   logic [6:0]         y100_ff, y100_in;
   logic [8:0]         y400_ff, y400_in;
   logic [3:0]         month_ff, month_in;
   logic [4:0]         hour_ff, hour_in;
   logic [5:0]         minute_ff, minute_in;

   logic [UNIT_W-1:0]  opa, opb;
   sub_result_type     sub_res;
   logic               leap;
   logic [4:0]         day_of_month;

   utc_sub_unit u_sub (
      .opa (opa),
      .opb (opb),
      .res (sub_res)
   );

   assign leap = (y400_ff == 9'd0) || ((y100_ff != 7'd0) && (y4_ff == 2'd0));

   always_comb begin
      opa = {1'b0, rem_ff};
      opb = SECS_IN_DAY;
      unique case (state_ff)
         ST_DIV: begin
            opa = {rem_ff, days_ff[DAYS_W-1]};
            opb = SECS_IN_DAY;
         end
         ST_YEAR: begin
            opa = UNIT_W'(days_ff);
            opb = UNIT_W'(leap ? 9'd366 : 9'd365);
         end
         ST_MONTH: begin
            opa = UNIT_W'(days_ff);
            opb = UNIT_W'(month_len(month_ff, leap));
         end
         ST_HOUR: begin
            opa = {1'b0, rem_ff};
            opb = SECS_IN_HOUR << step_ff[2:0];
         end
         ST_MIN: begin
            opa = {1'b0, rem_ff};
            opb = SECS_IN_MIN << step_ff[2:0];
         end
         default: begin
            opa = {1'b0, rem_ff};
            opb = SECS_IN_DAY;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      days_in   = days_ff;
      step_in   = step_ff;
      year_in   = year_ff;
      y4_in     = y4_ff;
      y100_in   = y100_ff;
      y400_in   = y400_ff;
      month_in  = month_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               // upper half is below 86400, so the first 16 quotient bits are zero
               rem_in    = {1'b0, req_tdata[31:16]};
               days_in   = req_tdata[15:0];
               step_in   = 4'd0;
               year_in   = YEAR_INIT;
               y4_in     = Y4_INIT;
               y100_in   = Y100_INIT;
               y400_in   = Y400_INIT;
               month_in  = MONTH_JAN;
               hour_in   = 5'd0;
               minute_in = 6'd0;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = sub_res.value[SOD_W-1:0];
            days_in = {days_ff[DAYS_W-2:0], sub_res.ge};
            step_in = step_ff + 4'd1;
            if (step_ff == DIV_LAST_STEP) begin
               state_in = ST_YEAR;
            end
         end
         ST_YEAR: begin
            if (sub_res.ge) begin
               days_in = sub_res.value[DAYS_W-1:0];
               year_in = year_ff + 12'd1;
               y4_in   = y4_ff + 2'd1;
               y100_in = (y100_ff == 7'd99)  ? 7'd0 : y100_ff + 7'd1;
               y400_in = (y400_ff == 9'd399) ? 9'd0 : y400_ff + 9'd1;
            end else begin
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if (sub_res.ge && (month_ff != MONTH_DEC)) begin
               days_in  = sub_res.value[DAYS_W-1:0];
               month_in = month_ff + 4'd1;
            end else begin
               step_in  = HOUR_TOP_BIT;
               state_in = ST_HOUR;
            end
         end
         ST_HOUR: begin
            rem_in  = sub_res.value[SOD_W-1:0];
            hour_in = {hour_ff[3:0], sub_res.ge};
            step_in = step_ff - 4'd1;
            if (step_ff == 4'd0) begin
               step_in  = MIN_TOP_BIT;
               state_in = ST_MIN;
            end
         end
         ST_MIN: begin
            rem_in    = sub_res.value[SOD_W-1:0];
            minute_in = {minute_ff[4:0], sub_res.ge};
            step_in   = step_ff - 4'd1;
            if (step_ff == 4'd0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      days_ff   <= days_in;
      step_ff   <= step_in;
      year_ff   <= year_in;
      y4_ff     <= y4_in;
      y100_ff   <= y100_in;
      y400_ff   <= y400_in;
      month_ff  <= month_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
   end

   assign day_of_month = days_ff[4:0] + 5'd1;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_DONE);
   assign rsp_tdata  = {2'b00, rem_ff[5:0], minute_ff, hour_ff, day_of_month,
                        month_ff, year_ff};

`ifndef NO_ASSERTIONS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("accepting while a result is pending");

   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && step_ff == DIV_LAST_STEP) |=> (state_ff == ST_YEAR))
      else $error("day division did not end after 16 steps");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (month_ff >= MONTH_JAN && month_ff <= MONTH_DEC
                                 && days_ff < 16'd31))
      else $error("month or day out of range");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (hour_ff < 5'd24 && minute_ff < 6'd60
                                 && rem_ff < 17'd60))
      else $error("time of day out of range");
`endif

endmodule

// File: rtl/utc_sub_unit.sv
// Shared compare-and-subtract unit of the calendar converter.
// Depends on utc_pkg for the operand width and the result struct.
module utc_sub_unit
   import utc_pkg::*;
(
   input  logic [UNIT_W-1:0] opa,
   input  logic [UNIT_W-1:0] opb,
   output sub_result_type    res
);

   logic [UNIT_W:0] diff;

   assign diff      = {1'b0, opa} - {1'b0, opb};
   assign res.ge    = ~diff[UNIT_W];
   // restoring step: keep the minuend when the subtraction borrows
   assign res.value = diff[UNIT_W] ? opa : diff[UNIT_W-1:0];

endmodule

// File: sim/unix_time_to_calendar_tb.sv
// Self-checking testbench for unix_time_to_calendar: drives timestamps over the
// req_ stream and checks each rsp_ date/time against an in-bench calendar predictor.
// Depends on utc_pkg and the unix_time_to_calendar RTL.
`timescale 1ns / 1ps

module unix_time_to_calendar_tb;

   localparam int unsigned BASE_YEAR       = 1970;
   localparam int unsigned SECONDS_PER_DAY = 86400;
   localparam int unsigned SECONDS_PER_HR  = 3600;
   localparam int unsigned SECONDS_PER_MIN = 60;
   localparam int unsigned QUIET_LIMIT     = 5000;   // cycles without any transaction
   localparam int unsigned SETTLE_CYCLES   = 250;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } calendar_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;    // timestamp[31:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;          // year, month, day_of_month, hour, minute, second

   calendar_type pending_dates[$];
   int unsigned  timestamps_sent = 0;
   int unsigned  dates_checked   = 0;
   int unsigned  error_count     = 0;
   int unsigned  quiet_cycles    = 0;
   int unsigned  stall_left      = 0;
   bit           idle_enable     = 1'b1;

   unix_time_to_calendar #(
      .BASE_YEAR (BASE_YEAR)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   function automatic int unsigned is_leap(input int unsigned y);
      if (y % 400 == 0) return 1;
      if (y % 100 == 0) return 0;
      if (y % 4 == 0) return 1;
      return 0;
   endfunction

   function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
      case (m)
         2:           return 28 + is_leap(y);
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   function automatic calendar_type to_calendar(input logic [31:0] ts);
      int unsigned  days;
      int unsigned  sod;
      int unsigned  y;
      int unsigned  m;
      int unsigned  len;
      calendar_type c;
      days = ts / SECONDS_PER_DAY;
      sod  = ts % SECONDS_PER_DAY;
      y    = BASE_YEAR;
      m    = 1;
      while (days > 0) begin
         len = 365 + is_leap(y);
         if (days < len) break;
         days -= len;
         y++;
      end
      while (m < 12) begin
         len = days_in_month(m, y);
         if (days < len) break;
         days -= len;
         m++;
      end
      c.year         = y[11:0];
      c.month        = m[3:0];
      c.day_of_month = 5'(days + 1);
      c.hour         = 5'(sod / SECONDS_PER_HR);
      sod            = sod % SECONDS_PER_HR;
      c.minute       = 6'(sod / SECONDS_PER_MIN);
      c.second       = 6'(sod % SECONDS_PER_MIN);
      return c;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   task automatic send_timestamp(input logic [31:0] ts);
      int unsigned gap;
      gap = (idle_enable && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ts;
      do @(posedge clock); while (!req_tready);
      pending_dates.push_back(to_calendar(ts));
      timestamps_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_dates.size() != 0) @(posedge clock);
   endtask

   task automatic test_edge_values();
      logic [31:0] edges[$];
      edges = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
                32'd31535999, 32'd31536000, 32'd68169600, 32'd94694399,
                32'd951782400, 32'd951868800, 32'd978307199, 32'h7FFF_FFFF,
                32'h8000_0000, 32'd4102444800, 32'd4107542399, 32'd4107542400,
                32'd4133980799, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
      foreach (edges[i]) send_timestamp(edges[i]);
      // hold the sender until the block has answered everything
      drain_results();
   endtask

   task automatic test_uniform_random(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         // first stretch runs back to back on both sides
         idle_enable = (i >= count / 3);
         send_timestamp($urandom());
      end
      idle_enable = 1'b1;
   endtask

   task automatic test_midnight_crossings(input int unsigned count);
      longint unsigned ts;
      int unsigned     day;
      for (int unsigned i = 0; i < count; i++) begin
         day = $urandom_range(0, 49710);
         case ($urandom_range(0, 3))
            0:       ts = longint'(day) * SECONDS_PER_DAY;
            1:       ts = longint'(day) * SECONDS_PER_DAY + SECONDS_PER_DAY - 1;
            2:       ts = longint'(day) * SECONDS_PER_DAY + $urandom_range(0, 23) * 3600;
            default: ts = longint'(day) * SECONDS_PER_DAY + $urandom_range(0, 86399);
         endcase
         if (ts <= 64'hFFFF_FFFF) send_timestamp(ts[31:0]);
      end
   endtask

   // year starts and the end of February, including century years
   task automatic test_new_year_crossings(input int unsigned count);
      longint unsigned ts;
      int unsigned     y;
      int unsigned     days;
      for (int unsigned i = 0; i < count; i++) begin
         y    = $urandom_range(BASE_YEAR + 1, 2106);
         days = 0;
         for (int unsigned yy = BASE_YEAR; yy < y; yy++) days += 365 + is_leap(yy);
         case ($urandom_range(0, 3))
            0:       ts = longint'(days) * SECONDS_PER_DAY - 1;
            1:       ts = longint'(days) * SECONDS_PER_DAY;
            2:       ts = longint'(days + 59) * SECONDS_PER_DAY;
            default: ts = longint'(days + 60) * SECONDS_PER_DAY - 1;
         endcase
         if (ts <= 64'hFFFF_FFFF) send_timestamp(ts[31:0]);
      end
   endtask

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      calendar_type got;
      calendar_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.year         = rsp_tdata[11:0];
         got.month        = rsp_tdata[15:12];
         got.day_of_month = rsp_tdata[20:16];
         got.hour         = rsp_tdata[25:21];
         got.minute       = rsp_tdata[31:26];
         got.second       = rsp_tdata[37:32];
         if (pending_dates.size() == 0) begin
            $error("unexpected result transaction, tdata %h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_dates.pop_front();
            check_field("year", want.year, got.year);
            check_field("month", want.month, got.month);
            check_field("day_of_month", want.day_of_month, got.day_of_month);
            check_field("hour", want.hour, got.hour);
            check_field("minute", want.minute, got.minute);
            check_field("second", want.second, got.second);
            dates_checked++;
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= pick_gap() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edge_values();
      test_uniform_random(300);
      test_midnight_crossings(150);
      drain_results();
      test_new_year_crossings(150);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Converted %0d timestamps, checked %0d dates: epoch and 32-bit limits,",
               timestamps_sent, dates_checked);
      $display("leap and century years, midnight and new-year crossings, random spread");
      if (error_count == 0 && pending_dates.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/utc_pkg.sv
rtl/utc_sub_unit.sv
rtl/unix_time_to_calendar.sv
sim/unix_time_to_calendar_tb.sv
